@@ rtl/wsfd_pkg.sv @@
// package for the websocket frame decoder: phase and result types, error codes,
// queue entry layout and header constants. depends on nothing.
`timescale 1ns / 1ps

package wsfd_pkg;

    localparam int LENGTH_WIDTH_DEFAULT = 63;
    localparam int QUEUE_DEPTH          = 4;

    localparam int LEN_OUT_WIDTH = 63;

    localparam logic [6:0]  LEN_EXT16 = 7'd126;
    localparam logic [6:0]  LEN_EXT64 = 7'd127;
    localparam logic [63:0] CTRL_MAX  = 64'd125;

    localparam logic [2:0] ERR_OK        = 3'd0;
    localparam logic [2:0] ERR_TRUNC     = 3'd1;
    localparam logic [2:0] ERR_RSV       = 3'd2;
    localparam logic [2:0] ERR_OPCODE    = 3'd3;
    localparam logic [2:0] ERR_LEN_BIG   = 3'd4;
    localparam logic [2:0] ERR_CTRL_LONG = 3'd5;
    localparam logic [2:0] ERR_CTRL_FRAG = 3'd6;

    localparam logic [3:0] OPC_CONT   = 4'd0;
    localparam logic [3:0] OPC_TEXT   = 4'd1;
    localparam logic [3:0] OPC_BINARY = 4'd2;
    localparam logic [3:0] OPC_CLOSE  = 4'd8;
    localparam logic [3:0] OPC_PING   = 4'd9;
    localparam logic [3:0] OPC_PONG   = 4'd10;

    typedef enum logic [2:0] {
        PH_HDR1,
        PH_HDR2,
        PH_EXTLEN,
        PH_KEY,
        PH_PAYLOAD,
        PH_DROP
    } phase_t;

    // what one accepted byte leaves for the back end
    typedef enum logic [2:0] {
        EMIT_NONE,
        EMIT_TRUNC,
        EMIT_REPORT,
        EMIT_LEN_BIG,
        EMIT_DATA_MORE,
        EMIT_DATA_END,
        EMIT_DATA_TRUNC
    } emit_t;

    typedef struct packed {
        logic [7:0]               data;
        logic [7:0]               key;
        logic                     xor_en;
        logic                     data_valid;
        logic                     frame_done;
        logic                     fin;
        logic [3:0]               opcode;
        logic                     masked;
        logic [LEN_OUT_WIDTH-1:0] length;
        logic [2:0]               err;
    } entry_t;

endpackage

@@ rtl/wsfd_front.sv @@
// front end of the websocket frame decoder: header parser, one byte per cycle while accept is high,
// classifies each accepted byte and writes a queue entry for each one that leaves a result. depends on wsfd_pkg.
`timescale 1ns / 1ps

module wsfd_front #(
    parameter int LENGTH_WIDTH = wsfd_pkg::LENGTH_WIDTH_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  logic [7:0]           in_byte,
    input  logic                 in_last,
    output logic                 entry_push,
    output wsfd_pkg::entry_t     entry
);

    wsfd_pkg::phase_t phase_reg, phase_next;
    logic                    fin_reg, fin_next;
    logic [3:0]              opc_reg, opc_next;
    logic [2:0]              herr_reg, herr_next;
    logic                    masked_reg, masked_next;
    logic [63:0]             len_reg, len_next;
    logic [2:0]              fcnt_reg, fcnt_next;
    logic [31:0]             key_reg, key_next;
    logic [LENGTH_WIDTH-1:0] rem_reg, rem_next;
    logic [1:0]              kpos_reg, kpos_next;
    logic                    skip_reg, skip_next;

    wsfd_pkg::emit_t kind;

    function automatic logic opcode_ok(input logic [3:0] op);
        return op == wsfd_pkg::OPC_CONT || op == wsfd_pkg::OPC_TEXT
            || op == wsfd_pkg::OPC_BINARY || op == wsfd_pkg::OPC_CLOSE
            || op == wsfd_pkg::OPC_PING || op == wsfd_pkg::OPC_PONG;
    endfunction

    // next state and classification
    always_comb
    begin
        logic [6:0]              len7;
        logic [63:0]             len_sh;
        logic [LENGTH_WIDTH-1:0] rem_dec;
        logic                    after_len;
        logic                    hdr_done;
        logic [2:0]              ctrl_err;

        phase_next  = phase_reg;
        fin_next    = fin_reg;
        opc_next    = opc_reg;
        herr_next   = herr_reg;
        masked_next = masked_reg;
        len_next    = len_reg;
        fcnt_next   = fcnt_reg;
        key_next    = key_reg;
        rem_next    = rem_reg;
        kpos_next   = kpos_reg;
        skip_next   = skip_reg;
        kind        = wsfd_pkg::EMIT_NONE;
        after_len   = 1'b0;
        hdr_done    = 1'b0;
        ctrl_err    = wsfd_pkg::ERR_OK;
        len7        = in_byte[6:0];
        len_sh      = {len_reg[55:0], in_byte};
        rem_dec     = rem_reg - {{(LENGTH_WIDTH-1){1'b0}}, 1'b1};

        if (accept)
        begin
            case (phase_reg)
                wsfd_pkg::PH_HDR1:
                begin
                    fin_next    = in_byte[7];
                    opc_next    = in_byte[3:0];
                    masked_next = 1'b0;
                    len_next    = '0;
                    skip_next   = 1'b0;
                    if (in_byte[6:4] != 3'b000)
                        herr_next = wsfd_pkg::ERR_RSV;
                    else if (!opcode_ok(in_byte[3:0]))
                        herr_next = wsfd_pkg::ERR_OPCODE;
                    else
                        herr_next = wsfd_pkg::ERR_OK;
                    if (in_last)
                        kind = wsfd_pkg::EMIT_TRUNC;
                    else
                        phase_next = wsfd_pkg::PH_HDR2;
                end
                wsfd_pkg::PH_HDR2:
                begin
                    masked_next = in_byte[7];
                    if (herr_reg != wsfd_pkg::ERR_OK)
                    begin
                        len_next   = {57'd0, len7};
                        phase_next = in_last ? wsfd_pkg::PH_HDR1 : wsfd_pkg::PH_DROP;
                        kind       = wsfd_pkg::EMIT_REPORT;
                    end
                    else if (len7 == wsfd_pkg::LEN_EXT16 || len7 == wsfd_pkg::LEN_EXT64)
                    begin
                        len_next = '0;
                        if (in_last)
                            kind = wsfd_pkg::EMIT_TRUNC;
                        else
                        begin
                            fcnt_next  = (len7 == wsfd_pkg::LEN_EXT16) ? 3'd1 : 3'd7;
                            phase_next = wsfd_pkg::PH_EXTLEN;
                        end
                    end
                    else
                    begin
                        len_next  = {57'd0, len7};
                        after_len = 1'b1;
                    end
                end
                wsfd_pkg::PH_EXTLEN:
                begin
                    len_next = len_sh;
                    if (fcnt_reg != 3'd0)
                    begin
                        fcnt_next = fcnt_reg - 3'd1;
                        if (in_last)
                            kind = wsfd_pkg::EMIT_TRUNC;
                    end
                    else if ((len_sh >> LENGTH_WIDTH) != 64'd0)
                    begin
                        phase_next = in_last ? wsfd_pkg::PH_HDR1 : wsfd_pkg::PH_DROP;
                        kind       = wsfd_pkg::EMIT_LEN_BIG;
                    end
                    else
                        after_len = 1'b1;
                end
                wsfd_pkg::PH_KEY:
                begin
                    key_next = {key_reg[23:0], in_byte};
                    if (fcnt_reg != 3'd0)
                    begin
                        fcnt_next = fcnt_reg - 3'd1;
                        if (in_last)
                            kind = wsfd_pkg::EMIT_TRUNC;
                    end
                    else
                        hdr_done = 1'b1;
                end
                wsfd_pkg::PH_PAYLOAD:
                begin
                    kpos_next = kpos_reg + 2'd1;
                    rem_next  = rem_dec;
                    if (rem_dec == '0)
                    begin
                        phase_next = wsfd_pkg::PH_HDR1;
                        kind = skip_reg ? wsfd_pkg::EMIT_REPORT : wsfd_pkg::EMIT_DATA_END;
                    end
                    else if (in_last)
                    begin
                        phase_next = wsfd_pkg::PH_HDR1;
                        kind = skip_reg ? wsfd_pkg::EMIT_TRUNC : wsfd_pkg::EMIT_DATA_TRUNC;
                    end
                    else if (!skip_reg)
                        kind = wsfd_pkg::EMIT_DATA_MORE;
                end
                default:
                begin
                    phase_next = in_last ? wsfd_pkg::PH_HDR1 : wsfd_pkg::PH_DROP;
                end
            endcase

            // length settled: mask key next, or straight to the payload
            if (after_len)
            begin
                if (masked_next)
                begin
                    if (in_last)
                        kind = wsfd_pkg::EMIT_TRUNC;
                    else
                    begin
                        fcnt_next  = 3'd3;
                        key_next   = '0;
                        phase_next = wsfd_pkg::PH_KEY;
                    end
                end
                else
                    hdr_done = 1'b1;
            end

            // header complete: control frame checks
            if (hdr_done)
            begin
                if (opc_reg[3] && len_next > wsfd_pkg::CTRL_MAX)
                    ctrl_err = wsfd_pkg::ERR_CTRL_LONG;
                else if (opc_reg[3] && !fin_reg)
                    ctrl_err = wsfd_pkg::ERR_CTRL_FRAG;
                herr_next = ctrl_err;
                skip_next = 1'b0;
                if (len_next == 64'd0)
                begin
                    phase_next = wsfd_pkg::PH_HDR1;
                    kind       = wsfd_pkg::EMIT_REPORT;
                end
                else if (in_last)
                    kind = wsfd_pkg::EMIT_TRUNC;
                else
                begin
                    skip_next  = (ctrl_err != wsfd_pkg::ERR_OK);
                    rem_next   = len_next[LENGTH_WIDTH-1:0];
                    kpos_next  = 2'd0;
                    phase_next = wsfd_pkg::PH_PAYLOAD;
                end
            end

            if (kind == wsfd_pkg::EMIT_TRUNC)
                phase_next = wsfd_pkg::PH_HDR1;
        end
    end

    // queue entry for the classified byte
    always_comb
    begin
        entry_push       = accept && (kind != wsfd_pkg::EMIT_NONE);
        entry.data       = 8'd0;
        entry.xor_en     = 1'b0;
        entry.data_valid = 1'b0;
        entry.frame_done = 1'b1;
        entry.err        = wsfd_pkg::ERR_OK;
        entry.fin        = fin_next;
        entry.opcode     = opc_next;
        entry.masked     = masked_next;
        entry.length     = len_next[wsfd_pkg::LEN_OUT_WIDTH-1:0];
        case (kpos_reg)
            2'd0:    entry.key = key_reg[31:24];
            2'd1:    entry.key = key_reg[23:16];
            2'd2:    entry.key = key_reg[15:8];
            default: entry.key = key_reg[7:0];
        endcase
        case (kind)
            wsfd_pkg::EMIT_TRUNC:   entry.err = wsfd_pkg::ERR_TRUNC;
            wsfd_pkg::EMIT_REPORT:  entry.err = herr_next;
            wsfd_pkg::EMIT_LEN_BIG: entry.err = wsfd_pkg::ERR_LEN_BIG;
            wsfd_pkg::EMIT_DATA_MORE,
            wsfd_pkg::EMIT_DATA_END,
            wsfd_pkg::EMIT_DATA_TRUNC:
            begin
                entry.data       = in_byte;
                entry.xor_en     = masked_reg;
                entry.data_valid = 1'b1;
                entry.frame_done = (kind != wsfd_pkg::EMIT_DATA_MORE);
                entry.err = (kind == wsfd_pkg::EMIT_DATA_TRUNC) ? wsfd_pkg::ERR_TRUNC
                                                                : wsfd_pkg::ERR_OK;
            end
            default:
            begin
                entry.frame_done = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= wsfd_pkg::PH_HDR1;
            fin_reg    <= 1'b0;
            opc_reg    <= 4'd0;
            herr_reg   <= wsfd_pkg::ERR_OK;
            masked_reg <= 1'b0;
            len_reg    <= '0;
            fcnt_reg   <= 3'd0;
            key_reg    <= '0;
            rem_reg    <= '0;
            kpos_reg   <= 2'd0;
            skip_reg   <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            fin_reg    <= fin_next;
            opc_reg    <= opc_next;
            herr_reg   <= herr_next;
            masked_reg <= masked_next;
            len_reg    <= len_next;
            fcnt_reg   <= fcnt_next;
            key_reg    <= key_next;
            rem_reg    <= rem_next;
            kpos_reg   <= kpos_next;
            skip_reg   <= skip_next;
        end
    end

endmodule

@@ rtl/wsfd_queue.sv @@
// short register queue between the parser and the output stage.
// depends on wsfd_pkg for the entry layout and depth.
`timescale 1ns / 1ps

module wsfd_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  wsfd_pkg::entry_t push_entry,
    output logic             full,
    input  logic             pop,
    output logic             empty,
    output wsfd_pkg::entry_t head
);

    localparam int PTR_W = $clog2(wsfd_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(wsfd_pkg::QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(wsfd_pkg::QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] LAST_C  = PTR_W'(wsfd_pkg::QUEUE_DEPTH - 1);

    wsfd_pkg::entry_t slot_reg [wsfd_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == DEPTH_C);
    assign empty   = (count_reg == '0);
    assign head    = slot_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == LAST_C) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == LAST_C) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_entry;
    end

endmodule

@@ rtl/wsfd_back.sv @@
// back end of the websocket frame decoder: unmasks the queued item and holds
// it in the output register until popped. depends on wsfd_pkg.
`timescale 1ns / 1ps

module wsfd_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_empty,
    input  wsfd_pkg::entry_t q_head,
    output logic             q_pop,
    input  logic             pop,
    output logic             empty,
    output logic [7:0]       out_byte,
    output logic             data_valid,
    output logic             frame_done,
    output logic             fin_flag,
    output logic [3:0]       frame_opcode,
    output logic             was_masked,
    output logic [62:0]      frame_length,
    output logic [2:0]       error_code
);

    logic             valid_reg, valid_next;
    logic [7:0]       byte_reg;
    wsfd_pkg::entry_t hold_reg;

    // refill when the register is free or being emptied this cycle
    assign q_pop = !q_empty && (!valid_reg || pop);

    always_comb
    begin
        valid_next = valid_reg;
        if (q_pop)
            valid_next = 1'b1;
        else if (pop)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            byte_reg <= q_head.xor_en ? (q_head.data ^ q_head.key) : q_head.data;
            hold_reg <= q_head;
        end
    end

    assign empty        = !valid_reg;
    assign out_byte     = byte_reg;
    assign data_valid   = hold_reg.data_valid;
    assign frame_done   = hold_reg.frame_done;
    assign fin_flag     = hold_reg.fin;
    assign frame_opcode = hold_reg.opcode;
    assign was_masked   = hold_reg.masked;
    assign frame_length = hold_reg.length;
    assign error_code   = hold_reg.err;

endmodule

@@ rtl/websocket_frame_decoder.sv @@
// top level of the websocket frame decoder: parser front end, item queue and
// output stage. depends on wsfd_pkg, wsfd_front, wsfd_queue and wsfd_back.
`timescale 1ns / 1ps

// the decoder takes one raw byte per clock while full is low: the header parser
// never stalls on a byte, so full rises only when the item queue behind the
// parser fills up because pop is held low. a result passes through the item
// queue into the output register before it reaches the output ports; header
// bytes, mask key bytes and skipped control payload give a result only where
// they end a frame or report an error, and dropped bytes give none. payload
// bytes come out already unmasked, and the frame fields ride on every result,
// with frame_done marking the one that closes a frame. after reserved bits, an
// unknown opcode or an oversized length the decoder reports the error, then
// drops bytes silently up to the end-of-buffer mark. LENGTH_WIDTH sets how
// many length bits are accepted and how wide the payload down-counter is.

module websocket_frame_decoder #(
    parameter int LENGTH_WIDTH = wsfd_pkg::LENGTH_WIDTH_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  in_byte,
    input  logic        in_last,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  out_byte,
    output logic        data_valid,
    output logic        frame_done,
    output logic        fin_flag,
    output logic [3:0]  frame_opcode,
    output logic        was_masked,
    output logic [62:0] frame_length,
    output logic [2:0]  error_code
);

    logic             accept;
    logic             entry_push;
    wsfd_pkg::entry_t entry;
    logic             q_empty;
    logic             q_pop;
    wsfd_pkg::entry_t q_head;

    // an item is taken whenever the queue has room for what it may produce
    assign accept = push && !full;

    wsfd_front #(
        .LENGTH_WIDTH (LENGTH_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .in_byte    (in_byte),
        .in_last    (in_last),
        .entry_push (entry_push),
        .entry      (entry)
    );

    // decouples the parser from a stalled consumer
    wsfd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (entry_push),
        .push_entry (entry),
        .full       (full),
        .pop        (q_pop),
        .empty      (q_empty),
        .head       (q_head)
    );

    wsfd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .q_head       (q_head),
        .q_pop        (q_pop),
        .pop          (pop),
        .empty        (empty),
        .out_byte     (out_byte),
        .data_valid   (data_valid),
        .frame_done   (frame_done),
        .fin_flag     (fin_flag),
        .frame_opcode (frame_opcode),
        .was_masked   (was_masked),
        .frame_length (frame_length),
        .error_code   (error_code)
    );

endmodule

@@ rtl/wsfd_checker.sv @@
// port-level checks for the websocket frame decoder, bound to the top level.
// depends on wsfd_pkg and websocket_frame_decoder.
`timescale 1ns / 1ps

module wsfd_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       empty,
    input logic       pop,
    input logic [7:0] out_byte,
    input logic       data_valid,
    input logic       frame_done,
    input logic [2:0] error_code
);

    // an item without payload always closes a frame
    a_nodata_done: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !data_valid |-> frame_done)
        else $error("result without payload does not end a frame");

    // an item without payload carries a zero byte
    a_nodata_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !data_valid |-> out_byte == 8'd0)
        else $error("non-payload result carries a byte");

    // any error ends the frame
    a_err_done: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && error_code != wsfd_pkg::ERR_OK |-> frame_done)
        else $error("error reported without frame end");

    // a payload byte can only be flagged as truncated
    a_data_err: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && data_valid && error_code != wsfd_pkg::ERR_OK
            |-> error_code == wsfd_pkg::ERR_TRUNC)
        else $error("payload byte with a header error");

    // a waiting item holds until taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(out_byte) && $stable(error_code))
        else $error("waiting result changed");

endmodule

bind websocket_frame_decoder wsfd_checker u_wsfd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .empty      (empty),
    .pop        (pop),
    .out_byte   (out_byte),
    .data_valid (data_valid),
    .frame_done (frame_done),
    .error_code (error_code)
);
